[sv/mfki_pkg.sv]
// ----------------------------------------------------------------------------
// mfki_pkg: shared types and constants
// Command and status codes, request and result structs, level decoding.
// ----------------------------------------------------------------------------
package mfki_pkg;

  localparam int MAX_KNOTS = 32;
  localparam int IDX_W     = $clog2(MAX_KNOTS);
  localparam int CNT_W     = $clog2(MAX_KNOTS + 1);
  localparam int LEVEL_W   = 20;
  localparam int NUM_W     = 28;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] knot_x;
    logic [7:0] knot_code;
    logic [7:0] query_value;
  } req_t;

  typedef struct packed {
    logic [7:0]         echo_value;
    logic [LEVEL_W-1:0] curve_level;
    logic [1:0]         status;
  } res_t;

  // work handed from front to back: either a finished result or a division
  typedef struct packed {
    logic               divide;
    logic [7:0]         echo_value;
    logic [LEVEL_W-1:0] level;
    logic [1:0]         status;
    logic [NUM_W-1:0]   numer;
    logic [7:0]         denom;
  } job_t;

  // (16+m)<<e in units of 1/256
  function automatic logic [LEVEL_W-1:0] decode_level(input logic [7:0] code);
    logic [LEVEL_W-1:0] base;
    base = LEVEL_W'({1'b1, code[3:0]});
    return base << code[7:4];
  endfunction

endpackage

[sv/mfki_front.sv]
// ----------------------------------------------------------------------------
// mfki_front: knot table, command decode and knot scan
// Holds the table, scans it one knot per cycle, forms the numerator.
// ----------------------------------------------------------------------------
module mfki_front (
  input  logic            clk,
  input  logic            rst,
  input  mfki_pkg::req_t  req,
  input  logic            push,
  output logic            full,
  output mfki_pkg::job_t  job,
  output logic            job_valid,
  input  logic            job_full
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_RDLO  = 3'd2;
  localparam logic [2:0] S_RDHI  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_SEND  = 3'd5;

  logic [7:0] pos_mem  [mfki_pkg::MAX_KNOTS];
  logic [7:0] code_mem [mfki_pkg::MAX_KNOTS];

  logic [2:0]                  state;
  logic [mfki_pkg::CNT_W-1:0]  knot_count;
  logic [mfki_pkg::CNT_W-1:0]  scan;
  logic [mfki_pkg::IDX_W-1:0]  rd_addr;
  logic [7:0]                  rd_pos;
  logic [7:0]                  rd_code;
  logic [7:0]                  v;
  logic [7:0]                  x1;
  logic [7:0]                  x2;
  logic [mfki_pkg::LEVEL_W-1:0] l1;
  logic [mfki_pkg::LEVEL_W-1:0] l2;
  logic [mfki_pkg::LEVEL_W-1:0] l2_dec;
  logic [mfki_pkg::NUM_W-1:0]  prod1;
  logic [mfki_pkg::NUM_W-1:0]  prod2;
  logic [mfki_pkg::CNT_W-1:0]  idx;
  logic [mfki_pkg::CNT_W-1:0]  lo;
  logic [mfki_pkg::CNT_W-1:0]  hi;
  logic [mfki_pkg::IDX_W-1:0]  hi_idx;
  logic                        found;
  logic                        accept;
  logic                        scan_stop;
  logic                        has_room;
  logic [1:0]                  acc_status;

  assign full     = (state != S_IDLE);
  assign accept   = push && !full;
  assign l2_dec   = mfki_pkg::decode_level(rd_code);
  assign has_room = (knot_count < mfki_pkg::CNT_W'(mfki_pkg::MAX_KNOTS));

  // status known at accept time
  always_comb begin
    acc_status = mfki_pkg::ST_OK;
    if (req.command == mfki_pkg::CMD_APPEND && !has_room) begin
      acc_status = mfki_pkg::ST_FULL;
    end else if (req.command == mfki_pkg::CMD_QUERY && knot_count == '0) begin
      acc_status = mfki_pkg::ST_EMPTY;
    end
  end

  // scan ends at the first knot above v or at the end of the table
  // rd_pos holds knot scan-1 when scan > 0
  always_comb begin
    found     = (scan != '0) && (rd_pos > v);
    scan_stop = found || (scan == knot_count);
    idx       = found ? scan - 1'b1 : scan;
    lo        = (idx != '0) ? idx - 1'b1 : '0;
    hi        = (idx < knot_count) ? idx : knot_count - 1'b1;
  end

  // read address chooses the next knot to look at
  always_comb begin
    unique case (state)
      S_SCAN:  rd_addr = scan_stop ? lo[mfki_pkg::IDX_W-1:0]
                                   : scan[mfki_pkg::IDX_W-1:0];
      default: rd_addr = hi_idx;
    endcase
  end

  // table memory with registered read
  always_ff @(posedge clk) begin
    if (accept && req.command == mfki_pkg::CMD_APPEND && has_room) begin
      pos_mem[knot_count[mfki_pkg::IDX_W-1:0]]  <= req.knot_x;
      code_mem[knot_count[mfki_pkg::IDX_W-1:0]] <= req.knot_code;
    end
    rd_pos  <= pos_mem[rd_addr];
    rd_code <= code_mem[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      knot_count <= '0;
      job_valid  <= 1'b0;
      hi_idx     <= '0;
    end else begin
      job_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            job.divide     <= 1'b0;
            job.level      <= '0;
            job.numer      <= '0;
            job.denom      <= '0;
            job.status     <= acc_status;
            job.echo_value <= (req.command == mfki_pkg::CMD_QUERY) ?
                              req.query_value : 8'd0;
            v              <= req.query_value;
            scan           <= '0;
            case (req.command)
              mfki_pkg::CMD_CLEAR: begin
                knot_count <= '0;
                state      <= S_SEND;
              end
              mfki_pkg::CMD_APPEND: begin
                if (has_room) begin
                  knot_count <= knot_count + 1'b1;
                end
                state <= S_SEND;
              end
              mfki_pkg::CMD_QUERY: begin
                if (knot_count == '0) begin
                  state <= S_SEND;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: state <= S_SEND;
            endcase
          end
        end
        S_SCAN: begin
          if (scan_stop) begin
            hi_idx <= hi[mfki_pkg::IDX_W-1:0];
            state  <= S_RDLO;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        S_RDLO: begin
          x1    <= rd_pos;
          l1    <= mfki_pkg::decode_level(rd_code);
          state <= S_RDHI;
        end
        S_RDHI: begin
          x2 <= rd_pos;
          l2 <= l2_dec;
          if (v <= x1) begin
            job.level <= l1;
            state     <= S_SEND;
          end else if (v >= rd_pos) begin
            job.level <= l2_dec;
            state     <= S_SEND;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          job.divide <= 1'b1;
          job.numer  <= prod1 + prod2;
          job.denom  <= x2 - x1;
          state      <= S_SEND;
        end
        S_SEND: begin
          if (!job_full) begin
            job_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // two narrow products: 20 x 8 bits each
  assign prod1 = mfki_pkg::NUM_W'(l1) * mfki_pkg::NUM_W'(x2 - v);
  assign prod2 = mfki_pkg::NUM_W'(l2) * mfki_pkg::NUM_W'(v - x1);

endmodule

[sv/mfki_queue.sv]
// ----------------------------------------------------------------------------
// mfki_queue: two-entry job queue
// Decouples the scan front from the divide back.
// ----------------------------------------------------------------------------
module mfki_queue (
  input  logic           clk,
  input  logic           rst,
  input  mfki_pkg::job_t wr_data,
  input  logic           wr,
  output logic           full,
  output mfki_pkg::job_t rd_data,
  output logic           empty,
  input  logic           rd
);

  mfki_pkg::job_t slots [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_data = slots[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr && !full) begin
      slots[wptr] <= wr_data;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (wr && !full) wptr <= ~wptr;
      if (rd && !empty) rptr <= ~rptr;
      count <= count + {1'b0, wr && !full} - {1'b0, rd && !empty};
    end
  end

endmodule

[sv/mfki_back.sv]
// ----------------------------------------------------------------------------
// mfki_back: restoring divider and result register
// One quotient bit per cycle, then holds the result until popped.
// ----------------------------------------------------------------------------
module mfki_back (
  input  logic           clk,
  input  logic           rst,
  input  mfki_pkg::job_t job,
  input  logic           job_empty,
  output logic           job_pop,
  output mfki_pkg::res_t res,
  output logic           empty,
  input  logic           pop
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_DIV  = 2'd1;
  localparam logic [1:0] B_OUT  = 2'd2;

  logic [1:0]                 state;
  logic [mfki_pkg::NUM_W-1:0] quo;
  logic [mfki_pkg::NUM_W-1:0] quo_next;
  logic [8:0]                 rem;
  logic [8:0]                 rem_next;
  logic [7:0]                 den;
  logic [4:0]                 cnt;
  logic [8:0]                 trial;
  logic                       out_free;

  assign empty    = (state != B_OUT);
  assign out_free = (state == B_IDLE);
  assign job_pop  = out_free && !job_empty;
  assign trial    = {rem[7:0], quo[mfki_pkg::NUM_W-1]} - {1'b0, den};

  // shift in one numerator bit, subtract when it fits
  always_comb begin
    if (!trial[8] || rem[8]) begin
      rem_next = trial;
      quo_next = {quo[mfki_pkg::NUM_W-2:0], 1'b1};
    end else begin
      rem_next = {rem[7:0], quo[mfki_pkg::NUM_W-1]};
      quo_next = {quo[mfki_pkg::NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (!job_empty) begin
            res.echo_value  <= job.echo_value;
            res.status      <= job.status;
            res.curve_level <= job.level;
            quo             <= job.numer;
            den             <= job.denom;
            rem             <= '0;
            cnt             <= 5'(mfki_pkg::NUM_W - 1);
            state           <= job.divide ? B_DIV : B_OUT;
          end
        end
        B_DIV: begin
          rem <= rem_next;
          quo <= quo_next;
          // quotient lands in the level on the last step
          if (cnt == 0) begin
            res.curve_level <= quo_next[mfki_pkg::LEVEL_W-1:0];
            state           <= B_OUT;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        B_OUT: begin
          if (pop) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

[sv/minifloat_knot_linear_interpolator.sv]
// ----------------------------------------------------------------------------
// minifloat_knot_linear_interpolator: piecewise-linear curve over knots
// Front scans the knot table, back divides; a two-entry queue between.
// ----------------------------------------------------------------------------
//  channel   handshake      payload
//  request   push / full    req  (command, knot_x, knot_code, query_value)
//  result    pop / empty    res  (echo_value, curve_level, status)
//
// clear and append pass straight to the send state; a query scans in the
// front (one knot per cycle in the scan) and may then divide in the back.
// reset empties the table and the queue; no clearing pass is needed.
// a held result stalls the back; a full queue stalls the front.
// ----------------------------------------------------------------------------
module minifloat_knot_linear_interpolator (
  input  logic           clk,
  input  logic           rst,
  input  mfki_pkg::req_t req,
  input  logic           push,
  output logic           full,
  output mfki_pkg::res_t res,
  output logic           empty,
  input  logic           pop
);

  mfki_pkg::job_t f_job;
  mfki_pkg::job_t q_job;
  logic           f_valid;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  mfki_pkg::res_t b_res;

  mfki_front u_front (
    .clk(clk), .rst(rst), .req(req), .push(push), .full(full),
    .job(f_job), .job_valid(f_valid), .job_full(q_full)
  );

  mfki_queue u_queue (
    .clk(clk), .rst(rst), .wr_data(f_job), .wr(f_valid), .full(q_full),
    .rd_data(q_job), .empty(q_empty), .rd(q_pop)
  );

  mfki_back u_back (
    .clk(clk), .rst(rst), .job(q_job), .job_empty(q_empty), .job_pop(q_pop),
    .res(b_res), .empty(empty), .pop(pop)
  );

  assign res = b_res;

endmodule

// ----------------------------------------------------------------------------
// mfki_checker: port-level checks on the interpolator
// Reset state, held results and legal status codes.
// ----------------------------------------------------------------------------
module mfki_checker (
  input logic           clk,
  input logic           rst,
  input logic           full,
  input mfki_pkg::res_t res,
  input logic           empty,
  input logic           pop
);

  // reset leaves both sides idle
  a_reset_idle: assert property (@(posedge clk) rst |=> (!full && empty));

  // a waiting result holds still until popped
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(res)));

  // status is one of the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (res.status == mfki_pkg::ST_OK || res.status == mfki_pkg::ST_EMPTY ||
                res.status == mfki_pkg::ST_FULL));

  // an error result carries no level
  a_error_level: assert property (@(posedge clk) disable iff (rst)
    (!empty && res.status != mfki_pkg::ST_OK) |-> (res.curve_level == '0));

endmodule

bind minifloat_knot_linear_interpolator mfki_checker u_checker (
  .clk(clk), .rst(rst), .full(full), .res(res), .empty(empty), .pop(pop)
);
